// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== hdl/jcsq_pkg.sv =====
// Shared types, constants and the sequencer program for the joystick calibration core.
// No dependencies.
package jcsq_pkg;

	// Field widths
	localparam int SAMPLE_W = 10;
	localparam int SCALED_W = 10;
	localparam int REGION_W = 3;
	localparam int ACCUM_W  = 16;
	localparam int COUNT_W  = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int IN_TDATA_W  = 24;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 32;

	// Divider geometry: two quotient bits per cycle
	localparam int DIV_W     = 20;
	localparam int DEN_W     = 10;
	localparam int DIV_STEPS = DIV_W / 2;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	// Scale and calibration constants
	localparam logic [SCALED_W-1:0] HALF_SCALE = 10'd500;
	localparam logic [SCALED_W-1:0] FULL_SCALE = 10'd1000;
	localparam logic [SAMPLE_W-1:0] LOWEST_INIT  = 10'd1000;
	localparam logic [SAMPLE_W-1:0] HIGHEST_INIT = 10'd0;
	localparam logic [SAMPLE_W-1:0] REST_INIT    = 10'd500;
	localparam logic [COUNT_W-1:0]  MAX_REST_SAMPLES = 7'd64;

	// Configuration reset values
	localparam logic [9:0] MIDPOINT_INIT = 10'd500;
	localparam logic [8:0] INNER_INIT    = 9'd50;
	localparam logic [8:0] MIDDLE_INIT   = 9'd200;
	localparam logic [8:0] OUTER_INIT    = 9'd400;
	localparam logic [COUNT_W-1:0] CENTER_COUNT_INIT = 7'd20;

	// Region codes
	localparam logic signed [REGION_W-1:0] REG_P3 = 3'sd3;
	localparam logic signed [REGION_W-1:0] REG_P2 = 3'sd2;
	localparam logic signed [REGION_W-1:0] REG_P1 = 3'sd1;
	localparam logic signed [REGION_W-1:0] REG_ZERO = 3'sd0;
	localparam logic signed [REGION_W-1:0] REG_N1 = -3'sd1;
	localparam logic signed [REGION_W-1:0] REG_N2 = -3'sd2;
	localparam logic signed [REGION_W-1:0] REG_N3 = -3'sd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIDPOINT     = 3'd0,
		CFG_INNER        = 3'd1,
		CFG_MIDDLE       = 3'd2,
		CFG_OUTER        = 3'd3,
		CFG_CENTER_COUNT = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_RUN     = 2'd0,
		PH_CENTER  = 2'd1,
		PH_RANGE   = 2'd2,
		PH_RESTART = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		SC_ZERO,
		SC_FULL,
		SC_HALF,
		SC_LOW,
		SC_HIGH
	} scale_mode_t;

	typedef struct packed {
		scale_mode_t       mode;
		logic [DIV_W-1:0]  num;
		logic [DEN_W-1:0]  den;
	} scale_job_t;

	// Microcode fields
	typedef enum logic [2:0] {
		DS_NONE,
		DS_XAVG,
		DS_YAVG,
		DS_XSCALE,
		DS_YSCALE
	} div_sel_t;

	typedef enum logic [2:0] {
		ST_NONE,
		ST_XREST,
		ST_YREST,
		ST_XSCALED,
		ST_YSCALED,
		ST_OUT
	} store_sel_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_INPUT,
		C_NO_AVG,
		C_DIV_BUSY,
		C_OUT_FULL
	} cond_t;

	localparam int STEP_W = 4;

	localparam logic [STEP_W-1:0] STEP_IDLE        = 4'd0;
	localparam logic [STEP_W-1:0] STEP_DISPATCH    = 4'd1;
	localparam logic [STEP_W-1:0] STEP_XAVG        = 4'd2;
	localparam logic [STEP_W-1:0] STEP_XAVG_WAIT   = 4'd3;
	localparam logic [STEP_W-1:0] STEP_YAVG        = 4'd4;
	localparam logic [STEP_W-1:0] STEP_YAVG_WAIT   = 4'd5;
	localparam logic [STEP_W-1:0] STEP_YREST       = 4'd6;
	localparam logic [STEP_W-1:0] STEP_XSCALE      = 4'd7;
	localparam logic [STEP_W-1:0] STEP_XSCALE_WAIT = 4'd8;
	localparam logic [STEP_W-1:0] STEP_YSCALE      = 4'd9;
	localparam logic [STEP_W-1:0] STEP_YSCALE_WAIT = 4'd10;
	localparam logic [STEP_W-1:0] STEP_YSCALED     = 4'd11;
	localparam logic [STEP_W-1:0] STEP_OUT_WAIT    = 4'd12;
	localparam logic [STEP_W-1:0] STEP_OUT         = 4'd13;

	typedef struct packed {
		div_sel_t            start;
		store_sel_t          store;
		cond_t               cond;
		logic [STEP_W-1:0]   target;
	} ucode_t;

	// Program ROM: jump to target when the condition holds, else fall through
	function automatic ucode_t ucode_rom(logic [STEP_W-1:0] step);
		ucode_t uc;
		unique case (step)
			STEP_IDLE:        uc = '{DS_NONE,   ST_NONE,    C_NO_INPUT, STEP_IDLE};
			STEP_DISPATCH:    uc = '{DS_NONE,   ST_NONE,    C_NO_AVG,   STEP_XSCALE};
			STEP_XAVG:        uc = '{DS_XAVG,   ST_NONE,    C_NEXT,     STEP_IDLE};
			STEP_XAVG_WAIT:   uc = '{DS_NONE,   ST_NONE,    C_DIV_BUSY, STEP_XAVG_WAIT};
			STEP_YAVG:        uc = '{DS_YAVG,   ST_XREST,   C_NEXT,     STEP_IDLE};
			STEP_YAVG_WAIT:   uc = '{DS_NONE,   ST_NONE,    C_DIV_BUSY, STEP_YAVG_WAIT};
			STEP_YREST:       uc = '{DS_NONE,   ST_YREST,   C_NEXT,     STEP_IDLE};
			STEP_XSCALE:      uc = '{DS_XSCALE, ST_NONE,    C_NEXT,     STEP_IDLE};
			STEP_XSCALE_WAIT: uc = '{DS_NONE,   ST_NONE,    C_DIV_BUSY, STEP_XSCALE_WAIT};
			STEP_YSCALE:      uc = '{DS_YSCALE, ST_XSCALED, C_NEXT,     STEP_IDLE};
			STEP_YSCALE_WAIT: uc = '{DS_NONE,   ST_NONE,    C_DIV_BUSY, STEP_YSCALE_WAIT};
			STEP_YSCALED:     uc = '{DS_NONE,   ST_YSCALED, C_NEXT,     STEP_IDLE};
			STEP_OUT_WAIT:    uc = '{DS_NONE,   ST_NONE,    C_OUT_FULL, STEP_OUT_WAIT};
			STEP_OUT:         uc = '{DS_NONE,   ST_OUT,     C_ALWAYS,   STEP_IDLE};
			default:          uc = '{DS_NONE,   ST_NONE,    C_ALWAYS,   STEP_IDLE};
		endcase
		return uc;
	endfunction

endpackage

// ===== hdl/jcsq_divider.sv =====
// Iterative unsigned restoring divider, two quotient bits per cycle.
// Depends on jcsq_pkg for its widths.
module jcsq_divider
	import jcsq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             busy,
	output logic [DIV_W-1:0] quotient
);

	logic [DIV_W-1:0]     quo_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;

	logic [DEN_W:0]   trial1, trial2;
	logic             ge1, ge2;
	logic [DEN_W-1:0] rem1, rem2;

	// Two shift-subtract steps per cycle
	always_comb begin
		trial1 = {rem_q, quo_q[DIV_W-1]};
		ge1    = trial1 >= {1'b0, den_q};
		rem1   = ge1 ? DEN_W'(trial1 - {1'b0, den_q}) : trial1[DEN_W-1:0];
		trial2 = {rem1, quo_q[DIV_W-2]};
		ge2    = trial2 >= {1'b0, den_q};
		rem2   = ge2 ? DEN_W'(trial2 - {1'b0, den_q}) : trial2[DEN_W-1:0];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Operands and partial results
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-3:0], ge1, ge2};
			rem_q <= rem2;
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/joystick_calibrate_scale_quantize_core.sv =====
// Joystick calibration, piecewise scaling to 0..1000 and region quantizer.
// Each accepted item runs the microcode sequencer: x scaling, y scaling, then the
// output load, which waits while the previous result is still held; the center sample
// that completes the average first runs the x and y averaging divisions. One item at a
// time: the input opens only in idle; the single shared divider serves every division.
// Reset (arst_n low): calibration, configuration, sequencer and output valid return to defaults at once.
module joystick_calibrate_scale_quantize_core
	import jcsq_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// config write channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	// input items
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [IN_TDATA_W-1:0]   s_axis_tdata,  // x_sample[9:0], y_sample[19:10], zero pad
	input  logic [IN_TUSER_W-1:0]   s_axis_tuser,  // phase[1:0]
	// result items
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [OUT_TDATA_W-1:0]  m_axis_tdata   // x_scaled[9:0], y_scaled[19:10],
	                                               // x_region[22:20], y_region[25:23], zero pad
);

	// Configuration registers
	logic [9:0]         midpoint_q;
	logic [8:0]         inner_q, middle_q, outer_q;
	logic [COUNT_W-1:0] center_count_q;

	// Calibration state
	logic [SAMPLE_W-1:0] x_lowest_q, x_highest_q, y_lowest_q, y_highest_q;
	logic [SAMPLE_W-1:0] x_rest_q, y_rest_q;
	logic [ACCUM_W-1:0]  x_accum_q, y_accum_q;
	logic [COUNT_W-1:0]  taken_q, need_q;
	logic                avg_due_q;

	// Working registers
	logic [SAMPLE_W-1:0] xs_q, ys_q;
	scale_mode_t         mode_q;
	logic [SCALED_W-1:0] x_scaled_q, y_scaled_q;
	logic [STEP_W-1:0]   pc_q, pc_d;

	// Output register
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic                in_fire, out_fire;
	logic [SAMPLE_W-1:0] in_x, in_y;
	phase_t              in_phase;
	logic [COUNT_W-1:0]  need_c;
	ucode_t              uc;
	logic                jump;
	logic                div_start, div_busy;
	logic [DIV_W-1:0]    div_num, div_quo;
	logic [DEN_W-1:0]    div_den;
	scale_job_t          job;
	logic [SCALED_W-1:0] finished;

	// Set up one axis scaling: special cases resolve to a fixed value
	function automatic scale_job_t scale_setup(logic [SAMPLE_W-1:0] s, logic [SAMPLE_W-1:0] lo,
			logic [SAMPLE_W-1:0] hi, logic [SAMPLE_W-1:0] rest);
		scale_job_t j;
		j.mode = SC_HALF;
		j.num  = '0;
		j.den  = '0;
		if (s < rest) begin
			if (rest <= lo || s <= lo) begin
				j.mode = SC_ZERO;
			end else begin
				j.mode = SC_LOW;
				j.num  = DIV_W'(s - lo) * DIV_W'(HALF_SCALE);
				j.den  = DEN_W'(rest - lo);
			end
		end else if (s > rest) begin
			if (hi <= rest) begin
				j.mode = SC_FULL;
			end else begin
				j.mode = SC_HIGH;
				j.num  = DIV_W'(s - rest) * DIV_W'(HALF_SCALE);
				j.den  = DEN_W'(hi - rest);
			end
		end
		return j;
	endfunction

	// Turn the quotient into the clamped scaled value
	function automatic logic [SCALED_W-1:0] scale_finish(scale_mode_t m, logic [DIV_W-1:0] q);
		logic [SCALED_W-1:0] r;
		case (m)
			SC_ZERO: r = '0;
			SC_FULL: r = FULL_SCALE;
			SC_LOW:  r = q[SCALED_W-1:0];
			SC_HIGH: r = (q >= DIV_W'(HALF_SCALE)) ? FULL_SCALE
			                                      : SCALED_W'(HALF_SCALE + q[SCALED_W-1:0]);
			default: r = HALF_SCALE;
		endcase
		return r;
	endfunction

	// Band lookup around the midpoint, tested in priority order
	function automatic logic signed [REGION_W-1:0] region_of(logic [SCALED_W-1:0] c,
			logic [9:0] mid, logic [8:0] a, logic [8:0] b, logic [8:0] d);
		logic signed [11:0] cv, m, pa, pb, pd, na, nb, nd;
		logic signed [REGION_W-1:0] r;
		cv = $signed({2'b00, c});
		m  = $signed({2'b00, mid});
		pa = m + $signed({3'b000, a});
		pb = m + $signed({3'b000, b});
		pd = m + $signed({3'b000, d});
		na = m - $signed({3'b000, a});
		nb = m - $signed({3'b000, b});
		nd = m - $signed({3'b000, d});
		if (cv > pa && cv < pb)       r = REG_P1;
		else if (cv > nb && cv < na)  r = REG_N1;
		else if (cv >= pb && cv < pd) r = REG_P2;
		else if (cv >= nd && cv < nb) r = REG_N2;
		else if (cv >= pd)            r = REG_P3;
		else if (cv <= nd)            r = REG_N3;
		else                          r = REG_ZERO;
		return r;
	endfunction

	// Handshakes and input fields
	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (pc_q == STEP_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_fire      = out_valid_q && m_axis_tready;
	assign in_x          = s_axis_tdata[SAMPLE_W-1:0];
	assign in_y          = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
	assign in_phase      = phase_t'(s_axis_tuser);

	// Effective number of center samples
	always_comb begin
		if (center_count_q == '0)                  need_c = COUNT_W'(1);
		else if (center_count_q > MAX_REST_SAMPLES) need_c = MAX_REST_SAMPLES;
		else                                       need_c = center_count_q;
	end

	// Sequencer: fetch and branch
	always_comb begin
		uc = ucode_rom(pc_q);
		case (uc.cond)
			C_ALWAYS:   jump = 1'b1;
			C_NO_INPUT: jump = !in_fire;
			C_NO_AVG:   jump = !avg_due_q;
			C_DIV_BUSY: jump = div_busy;
			C_OUT_FULL: jump = out_valid_q;
			default:    jump = 1'b0;
		endcase
		pc_d = jump ? uc.target : STEP_W'(pc_q + 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	// Divider operand select
	always_comb begin
		job       = scale_setup(xs_q, x_lowest_q, x_highest_q, x_rest_q);
		div_start = 1'b1;
		div_num   = '0;
		div_den   = '0;
		case (uc.start)
			DS_XAVG: begin
				div_num = DIV_W'(x_accum_q);
				div_den = DEN_W'(need_q);
			end
			DS_YAVG: begin
				div_num = DIV_W'(y_accum_q);
				div_den = DEN_W'(need_q);
			end
			DS_XSCALE: begin
				div_num = job.num;
				div_den = job.den;
			end
			DS_YSCALE: begin
				job     = scale_setup(ys_q, y_lowest_q, y_highest_q, y_rest_q);
				div_num = job.num;
				div_den = job.den;
			end
			default: div_start = 1'b0;
		endcase
	end

	assign finished = scale_finish(mode_q, div_quo);

	jcsq_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			midpoint_q     <= MIDPOINT_INIT;
			inner_q        <= INNER_INIT;
			middle_q       <= MIDDLE_INIT;
			outer_q        <= OUTER_INIT;
			center_count_q <= CENTER_COUNT_INIT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MIDPOINT:     midpoint_q     <= cfg_data[9:0];
				CFG_INNER:        inner_q        <= cfg_data[8:0];
				CFG_MIDDLE:       middle_q       <= cfg_data[8:0];
				CFG_OUTER:        outer_q        <= cfg_data[8:0];
				CFG_CENTER_COUNT: center_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Calibration state: phase update at acceptance, centers from the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_lowest_q  <= LOWEST_INIT;
			x_highest_q <= HIGHEST_INIT;
			y_lowest_q  <= LOWEST_INIT;
			y_highest_q <= HIGHEST_INIT;
			x_rest_q    <= REST_INIT;
			y_rest_q    <= REST_INIT;
			x_accum_q   <= '0;
			y_accum_q   <= '0;
			taken_q     <= '0;
			avg_due_q   <= 1'b0;
		end else if (in_fire) begin
			avg_due_q <= 1'b0;
			unique case (in_phase)
				PH_RESTART: begin
					x_lowest_q  <= LOWEST_INIT;
					x_highest_q <= HIGHEST_INIT;
					y_lowest_q  <= LOWEST_INIT;
					y_highest_q <= HIGHEST_INIT;
					x_rest_q    <= REST_INIT;
					y_rest_q    <= REST_INIT;
					x_accum_q   <= '0;
					y_accum_q   <= '0;
					taken_q     <= '0;
				end
				PH_CENTER: begin
					if (taken_q < need_c) begin
						x_accum_q <= x_accum_q + ACCUM_W'(in_x);
						y_accum_q <= y_accum_q + ACCUM_W'(in_y);
						taken_q   <= taken_q + 1'b1;
						avg_due_q <= (COUNT_W'(taken_q + 1'b1) == need_c);
					end
				end
				PH_RANGE: begin
					if (in_x < x_lowest_q)  x_lowest_q  <= in_x;
					if (in_x > x_highest_q) x_highest_q <= in_x;
					if (in_y < y_lowest_q)  y_lowest_q  <= in_y;
					if (in_y > y_highest_q) y_highest_q <= in_y;
				end
				default: ;
			endcase
		end else begin
			case (uc.store)
				ST_XREST: x_rest_q <= div_quo[SAMPLE_W-1:0];
				ST_YREST: y_rest_q <= div_quo[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Working payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			xs_q   <= in_x;
			ys_q   <= in_y;
			need_q <= need_c;
		end
		if (uc.start == DS_XSCALE || uc.start == DS_YSCALE) begin
			mode_q <= job.mode;
		end
		case (uc.store)
			ST_XSCALED: x_scaled_q <= finished;
			ST_YSCALED: y_scaled_q <= finished;
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uc.store == ST_OUT) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uc.store == ST_OUT) begin
			out_data_q <= {6'b000000,
				region_of(y_scaled_q, midpoint_q, inner_q, middle_q, outer_q),
				region_of(x_scaled_q, midpoint_q, inner_q, middle_q, outer_q),
				y_scaled_q, x_scaled_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== hdl/jcsq_checker.sv =====
// Port-level checks for the joystick calibration core, attached by bind.
// Depends on jcsq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jcsq_checker
	import jcsq_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// Result fields
	logic [SCALED_W-1:0] x_scaled, y_scaled;
	logic [REGION_W-1:0] x_region, y_region;
	logic                out_stall, in_fire;

	assign x_scaled  = m_axis_tdata[9:0];
	assign y_scaled  = m_axis_tdata[19:10];
	assign x_region  = m_axis_tdata[22:20];
	assign y_region  = m_axis_tdata[25:23];
	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign in_fire   = s_axis_tvalid && s_axis_tready;

	// A stalled result holds
	`CHK_NEXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

	// One item at a time: an accepted item closes the input for a while
	`CHK_NEXT(a_one_in_flight, clk, arst_n, in_fire, !s_axis_tready)

	// Scaled values never exceed full scale
	`CHK_IMPLY(a_scaled_range, clk, arst_n, m_axis_tvalid, x_scaled <= FULL_SCALE && y_scaled <= FULL_SCALE)

	// Regions stay within -3..3
	`CHK_IMPLY(a_region_range, clk, arst_n, m_axis_tvalid, x_region != 3'b100 && y_region != 3'b100)

endmodule

bind joystick_calibrate_scale_quantize_core jcsq_checker u_jcsq_checker (.*);

// ===== sim/joystick_calibrate_scale_quantize_core_test.sv =====
// Self-checking testbench for joystick_calibrate_scale_quantize_core: calibration
// sequences, scaling and region bands checked item by item against an in-bench predictor.
// Depends on jcsq_pkg and the core; no files, no arguments.
module joystick_calibrate_scale_quantize_core_test;
	import jcsq_pkg::*;

	localparam int LIMIT_CYCLES = 600000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 60;
	localparam int TARGET_ITEMS = 1400;
	localparam int PHASES       = 8;
	localparam int HALF         = HALF_SCALE;
	localparam int FULL         = FULL_SCALE;

	typedef struct {
		logic [SAMPLE_W-1:0] x;
		logic [SAMPLE_W-1:0] y;
		phase_t              ph;
	} stick_item_t;

	// Same bit order as m_axis_tdata[25:0]
	typedef struct packed {
		logic [REGION_W-1:0] yr;
		logic [REGION_W-1:0] xr;
		logic [SCALED_W-1:0] ys;
		logic [SCALED_W-1:0] xs;
	} position_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic [IN_TUSER_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// Predictor configuration
	int band_mid = MIDPOINT_INIT;
	int band_inner = INNER_INIT;
	int band_middle = MIDDLE_INIT;
	int band_outer = OUTER_INIT;
	int center_count = CENTER_COUNT_INIT;

	// Predictor calibration state
	int x_low = LOWEST_INIT;
	int x_high = HIGHEST_INIT;
	int y_low = LOWEST_INIT;
	int y_high = HIGHEST_INIT;
	int x_pivot = REST_INIT;
	int y_pivot = REST_INIT;
	logic [ACCUM_W-1:0] x_sum = '0;
	logic [ACCUM_W-1:0] y_sum = '0;
	int rest_taken = 0;

	stick_item_t pending_items[$];
	position_t positions_due[$];
	stick_item_t next_item;
	int items_queued = 0;
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	logic hold_start = 1'b0;
	int cycles = 0;

	joystick_calibrate_scale_quantize_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Rest samples needed for an average: zero counts as one, capped at the maximum
	function automatic int rest_need();
		if (center_count == 0) begin
			return 1;
		end
		if (center_count > MAX_REST_SAMPLES) begin
			return MAX_REST_SAMPLES;
		end
		return center_count;
	endfunction

	// Piecewise scaling around the center, truncating, clamped to 0..1000
	function automatic int scaled_position(int s, int lo, int hi, int ctr);
		int r;
		if (s < ctr) begin
			if (ctr - lo <= 0) begin
				return 0;
			end
			r = (s - lo) * HALF / (ctr - lo);
		end else if (s > ctr) begin
			if (hi - ctr <= 0) begin
				return FULL;
			end
			r = HALF + (s - ctr) * HALF / (hi - ctr);
		end else begin
			r = HALF;
		end
		if (r < 0) begin
			r = 0;
		end
		if (r > FULL) begin
			r = FULL;
		end
		return r;
	endfunction

	// Band of a scaled value; tests run in priority order
	function automatic logic [REGION_W-1:0] deflection_band(int c);
		if (c > band_mid + band_inner && c < band_mid + band_middle) begin
			return REG_P1;
		end
		if (c > band_mid - band_middle && c < band_mid - band_inner) begin
			return REG_N1;
		end
		if (c >= band_mid + band_middle && c < band_mid + band_outer) begin
			return REG_P2;
		end
		if (c >= band_mid - band_outer && c < band_mid - band_middle) begin
			return REG_N2;
		end
		if (c >= band_mid + band_outer) begin
			return REG_P3;
		end
		if (c <= band_mid - band_outer) begin
			return REG_N3;
		end
		return REG_ZERO;
	endfunction

	// Update calibration for one item, then scale and quantize both axes
	function automatic position_t predict_position(logic [SAMPLE_W-1:0] xs,
			logic [SAMPLE_W-1:0] ys, phase_t ph);
		position_t pos;
		int need;
		int xv;
		int yv;
		xv = xs;
		yv = ys;
		need = rest_need();
		case (ph)
			PH_RESTART: begin
				x_low = LOWEST_INIT;
				x_high = HIGHEST_INIT;
				y_low = LOWEST_INIT;
				y_high = HIGHEST_INIT;
				x_pivot = REST_INIT;
				y_pivot = REST_INIT;
				x_sum = '0;
				y_sum = '0;
				rest_taken = 0;
			end
			PH_CENTER: begin
				// extra rest samples are ignored until the next restart
				if (rest_taken < need) begin
					x_sum = x_sum + ACCUM_W'(xs);
					y_sum = y_sum + ACCUM_W'(ys);
					rest_taken++;
					if (rest_taken == need) begin
						x_pivot = int'(x_sum) / need;
						y_pivot = int'(y_sum) / need;
					end
				end
			end
			PH_RANGE: begin
				if (xv < x_low) begin
					x_low = xv;
				end
				if (xv > x_high) begin
					x_high = xv;
				end
				if (yv < y_low) begin
					y_low = yv;
				end
				if (yv > y_high) begin
					y_high = yv;
				end
			end
			default: begin
			end
		endcase
		pos.xs = SCALED_W'(scaled_position(xv, x_low, x_high, x_pivot));
		pos.ys = SCALED_W'(scaled_position(yv, y_low, y_high, y_pivot));
		pos.xr = deflection_band(pos.xs);
		pos.yr = deflection_band(pos.ys);
		return pos;
	endfunction

	// Input driver: predicts on each accepted item, loads the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				positions_due.push_back(predict_position(s_axis_tdata[9:0],
					s_axis_tdata[19:10], phase_t'(s_axis_tuser)));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_item = pending_items.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {4'b0, next_item.y, next_item.x};
					s_axis_tuser <= next_item.ph;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, started by a one-cycle request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_start) begin
			hold_left <= HOLD_CYCLES;
		end
	end

	// Output monitor: compare each result item with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (positions_due.size() == 0) begin
					if (mismatches < 10) begin
						$display("result item with nothing outstanding: tdata %h", m_axis_tdata);
					end
					mismatches++;
				end else begin
					automatic position_t want = positions_due.pop_front();
					automatic position_t got = m_axis_tdata[25:0];
					if (got != want) begin
						if (mismatches < 10) begin
							$display("exp/got xs %0d/%0d ys %0d/%0d xr %0d/%0d yr %0d/%0d",
								want.xs, got.xs, want.ys, got.ys,
								$signed(want.xr), $signed(got.xr),
								$signed(want.yr), $signed(got.yr));
						end
						mismatches++;
					end
				end
			end
			m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic write_register(cfg_idx_t idx, int value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_MIDPOINT:     band_mid = value % 1024;
			CFG_INNER:        band_inner = value % 512;
			CFG_MIDDLE:       band_middle = value % 512;
			CFG_OUTER:        band_outer = value % 512;
			CFG_CENTER_COUNT: center_count = value % 128;
			default: begin
			end
		endcase
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (pending_items.size() != 0 || s_axis_tvalid || positions_due.size() != 0);
	endtask

	task automatic offer(int x, int y, phase_t ph);
		stick_item_t it;
		it.x = SAMPLE_W'(x);
		it.y = SAMPLE_W'(y);
		it.ph = ph;
		pending_items.push_back(it);
		items_queued++;
	endtask

	// Random sample within spread of c, kept inside the ADC range
	function automatic int near(int c, int spread);
		int v;
		v = c + int'($urandom_range(2 * spread)) - spread;
		if (v < 0) begin
			v = 0;
		end
		if (v > 1023) begin
			v = 1023;
		end
		return v;
	endfunction

	// One well-formed calibration: restart, rest samples and range sweep in either order, then running
	task automatic queue_calibration_run();
		int cx;
		int cy;
		int spread;
		int reach;
		int n_center;
		int n_range;
		int n_run;
		bit range_first;
		cx = $urandom_range(100, 923);
		cy = $urandom_range(100, 923);
		spread = $urandom_range(0, 60);
		reach = $urandom_range(30, 523);
		n_center = rest_need() + $urandom_range(0, 2);
		if ($urandom_range(9) == 0) begin
			n_center = $urandom_range(0, n_center);
		end
		n_range = $urandom_range(1, 8);
		n_run = $urandom_range(8, 30);
		range_first = ($urandom_range(3) == 0);
		offer($urandom_range(1023), $urandom_range(1023), PH_RESTART);
		for (int seg = 0; seg < 2; seg++) begin
			if ((seg == 0) == range_first) begin
				for (int i = 0; i < n_range; i++) begin
					offer(near(cx, reach), near(cy, reach), PH_RANGE);
				end
			end else begin
				for (int i = 0; i < n_center; i++) begin
					offer(near(cx, spread), near(cy, spread), PH_CENTER);
				end
			end
		end
		for (int i = 0; i < n_run; i++) begin
			if ($urandom_range(9) == 0) begin
				// stray item of any kind
				offer($urandom_range(1023), $urandom_range(1023), phase_t'($urandom_range(3)));
			end else if ($urandom_range(1) == 0) begin
				offer(near(cx, reach + 50), near(cy, reach + 50), PH_RUN);
			end else begin
				offer($urandom_range(1023), $urandom_range(1023), PH_RUN);
			end
		end
	endtask

	initial begin
		int mid;
		int a;
		int b;
		int d;
		int cnt;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p <= PHASES; p++) begin
			if (p > 0) begin
				wait_drained();
			end
			// idling mix: none, sender, receiver, both
			case (p % 4)
				0: begin
					send_idle_pct <= 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct <= 45;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct <= 0;
					recv_stall_pct <= 45;
				end
				default: begin
					send_idle_pct <= 29;
					recv_stall_pct <= 29;
				end
			endcase
			// band and averaging settings for this phase
			a = $urandom_range(0, 500);
			b = $urandom_range(a, 500);
			d = $urandom_range(b, 500);
			mid = $urandom_range(0, 1000);
			cnt = $urandom_range(1, 12);
			case (p)
				0: begin
					mid = 500;
					a = 50;
					b = 200;
					d = 400;
					cnt = 3;
				end
				1: cnt = 20;
				2: begin
					mid = 0;
					a = 0;
					b = 0;
					d = 0;
					cnt = 1;
				end
				3: begin
					mid = 1000;
					a = 500;
					b = 500;
					d = 500;
					cnt = 64;
				end
				4: cnt = 0;
				5: begin
					// offsets out of order
					a = $urandom_range(0, 500);
					b = $urandom_range(0, 500);
					d = $urandom_range(0, 500);
					cnt = 127;
				end
				default: begin
				end
			endcase
			write_register(CFG_MIDPOINT, mid);
			write_register(CFG_INNER, a);
			write_register(CFG_MIDDLE, b);
			write_register(CFG_OUTER, d);
			write_register(CFG_CENTER_COUNT, cnt);
			if (p == 0) begin
				// calibration from reset: both spans negative, then the equal case
				offer(0, 1023, PH_RUN);
				offer(500, 500, PH_RUN);
				offer(1023, 0, PH_RUN);
				offer(0, 1023, PH_RANGE);
				offer(1023, 0, PH_RANGE);
				// three rest samples complete the average, the fourth is ignored
				offer(100, 900, PH_CENTER);
				offer(200, 800, PH_CENTER);
				offer(300, 700, PH_CENTER);
				offer(1023, 0, PH_CENTER);
				offer(200, 800, PH_RUN);
				offer(0, 1023, PH_RUN);
				offer(1023, 0, PH_RUN);
				offer(150, 950, PH_RUN);
				// narrow range: samples outside it clamp
				offer(0, 0, PH_RESTART);
				offer(300, 300, PH_RANGE);
				offer(700, 700, PH_RANGE);
				offer(0, 1023, PH_RUN);
				offer(400, 600, PH_RUN);
				offer(550, 450, PH_RUN);
				offer(512, 511, PH_CENTER);
				offer(512, 512, PH_RUN);
				// range collapsed onto the center: zero spans on both sides
				offer(0, 0, PH_RESTART);
				offer(500, 500, PH_RANGE);
				offer(499, 501, PH_RUN);
				offer(501, 499, PH_RUN);
			end else begin
				while (items_queued < 25 + p * (TARGET_ITEMS / PHASES)) begin
					queue_calibration_run();
				end
				if (p == 3 || p == 6) begin
					// receiver holds off while the sender keeps offering
					@(posedge clk);
					hold_start <= 1'b1;
					@(posedge clk);
					hold_start <= 1'b0;
				end
			end
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (positions_due.size() != 0) begin
			$display("results never delivered: %0d", positions_due.size());
		end
		if (mismatches == 0 && positions_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/jcsq_pkg.sv
hdl/jcsq_divider.sv
hdl/joystick_calibrate_scale_quantize_core.sv
hdl/jcsq_checker.sv
sim/joystick_calibrate_scale_quantize_core_test.sv
